// ===== hw/rtl/address_window_translator_top_assert.svh =====
// Assertion macros for the address window translator checker.
// Included by the checker file only; no other dependencies.
`ifndef ADDRESS_WINDOW_TRANSLATOR_TOP_ASSERT_SVH
`define ADDRESS_WINDOW_TRANSLATOR_TOP_ASSERT_SVH

// Check a property while out of reset.
`define AWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define AWT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/awt_pkg.sv =====
// Shared types and constants for the address window translator.
// No dependencies.
package awt_pkg;

  // Default number of windows
  localparam int NumWindowsDef = 8;
  // Width of the reported window index
  localparam int HitW = 6;

  localparam logic StatOk   = 1'b0;
  localparam logic StatFail = 1'b1;

  typedef enum logic {
    FuncLoad  = 1'b0,
    FuncXlate = 1'b1
  } func_e;

  // Item as it travels down the window chain
  typedef struct packed {
    func_e            func;
    logic [7:0]       idx;
    logic             enable;
    logic [31:0]      start_addr;
    logic [31:0]      end_addr;
    logic [63:0]      base;
    logic [31:0]      addr;
    logic             done;     // result already settled
    logic             status;
    logic [HitW-1:0]  hit;
    logic [63:0]      xaddr;
  } tok_t;

endpackage

// ===== hw/rtl/awt_cell.sv =====
// One window cell: holds one translation window and one pipeline stage.
// Depends on awt_pkg.
module awt_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  awt_pkg::tok_t tok_i,
  input  logic         valid_i,
  output logic         ready_o,
  output awt_pkg::tok_t tok_o,
  output logic         valid_o,
  input  logic         ready_i
);

  logic          win_en_q;
  logic [31:0]   win_start_q;
  logic [31:0]   win_end_q;
  logic [63:0]   win_base_q;
  logic          vld_q, vld_d;
  awt_pkg::tok_t tok_q, tok_d;
  logic          take;
  logic          wr;
  logic          match;

  assign ready_o = !vld_q || ready_i;
  assign take    = valid_i && ready_o;
  assign wr      = take && (tok_i.func == awt_pkg::FuncLoad) &&
                   (tok_i.idx == 8'(CELL_IDX));
  assign match   = (tok_i.addr >= win_start_q) && (tok_i.addr <= win_end_q);

  // Resolve a pending translate against this window
  always_comb begin
    tok_d = tok_i;
    if (tok_i.func == awt_pkg::FuncXlate && !tok_i.done && match) begin
      tok_d.done = 1'b1;
      if (win_en_q) begin
        tok_d.status = awt_pkg::StatOk;
        tok_d.hit    = awt_pkg::HitW'(CELL_IDX);
        tok_d.xaddr  = win_base_q + {32'b0, tok_i.addr - win_start_q};
      end
    end
  end

  // Window storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_en_q    <= 1'b0;
      win_start_q <= '0;
      win_end_q   <= '0;
      win_base_q  <= '0;
    end else if (wr) begin
      win_en_q    <= tok_i.enable;
      win_start_q <= tok_i.start_addr;
      win_end_q   <= tok_i.end_addr;
      win_base_q  <= tok_i.base;
    end
  end

  // Stage occupancy
  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o   = tok_q;
  assign valid_o = vld_q;

endmodule

// ===== hw/rtl/address_window_translator_top.sv =====
// Address window translator top level: entry logic and the chain of window cells.
// Depends on awt_pkg and awt_cell.
//
// Each item travels down a chain of NUM_WINDOWS cells, one cell per window, moving
// one cell per cycle while the next cell can take it. The chain is a pipeline:
// with the output taken every cycle the block accepts one item per cycle. A load
// writes its window as it passes that window's cell; a translate settles at the
// first cell whose range holds the address. The last cell's stage is the output
// register. Reset clears all windows at once.
module address_window_translator_top #(
  parameter int NUM_WINDOWS = awt_pkg::NumWindowsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [7:0]                window_index_i,
  input  logic                      enable_i,
  input  logic [31:0]               start_addr_i,
  input  logic [31:0]               end_addr_i,
  input  logic [63:0]               target_base_i,
  input  logic [31:0]               lookup_addr_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      status_o,
  output logic [awt_pkg::HitW-1:0]  hit_window_o,
  output logic [63:0]               translated_addr_o
);

  awt_pkg::tok_t tok [NUM_WINDOWS+1];
  logic          vld [NUM_WINDOWS+1];
  logic          rdy [NUM_WINDOWS+1];

  // Build the entering item; loads and zero lookups settle here
  always_comb begin
    tok[0]            = '0;
    tok[0].func       = awt_pkg::func_e'(func_i);
    tok[0].idx        = window_index_i;
    tok[0].enable     = enable_i;
    tok[0].start_addr = start_addr_i;
    tok[0].end_addr   = end_addr_i;
    tok[0].base       = target_base_i;
    tok[0].addr       = lookup_addr_i;
    if (awt_pkg::func_e'(func_i) == awt_pkg::FuncLoad) begin
      tok[0].done   = 1'b1;
      tok[0].status = (window_index_i >= 8'(NUM_WINDOWS)) ?
                      awt_pkg::StatFail : awt_pkg::StatOk;
    end else begin
      tok[0].done   = (lookup_addr_i == 32'd0);
      tok[0].status = awt_pkg::StatFail;
    end
  end

  assign vld[0]           = in_valid_i;
  assign in_ready_o       = rdy[0];
  assign rdy[NUM_WINDOWS] = out_ready_i;

  // Window cell chain
  for (genvar k = 0; k < NUM_WINDOWS; k++) begin : g_cell
    awt_cell #(
      .CELL_IDX(k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok[k]),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .tok_o   (tok[k+1]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1])
    );
  end

  assign out_valid_o       = vld[NUM_WINDOWS];
  assign status_o          = tok[NUM_WINDOWS].status;
  assign hit_window_o      = tok[NUM_WINDOWS].hit;
  assign translated_addr_o = tok[NUM_WINDOWS].xaddr;

endmodule

// ===== hw/rtl/awt_checker.sv =====
// Port-level checker for the address window translator, bound to the top level.
// Depends on address_window_translator_top_assert.svh and awt_pkg.
`include "address_window_translator_top_assert.svh"

module awt_checker #(
  parameter int NUM_WINDOWS = awt_pkg::NumWindowsDef
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic                     status_o,
  input logic [awt_pkg::HitW-1:0] hit_window_o,
  input logic [63:0]              translated_addr_o
);

  // Failed items carry zero fields
  `AWT_ASSERT(a_fail_zero, out_valid_o && status_o |-> hit_window_o == '0 && translated_addr_o == '0, "failed item with nonzero fields")

  // A hit names an existing window
  `AWT_ASSERT(a_hit_range, out_valid_o && !status_o |-> 32'(hit_window_o) < 32'(NUM_WINDOWS), "hit window out of range")

  // A stalled result holds
  `AWT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(hit_window_o) && $stable(translated_addr_o), "stalled result changed")

  // Nothing leaves during reset; checked once the async clear has settled
  `AWT_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind address_window_translator_top awt_checker #(
  .NUM_WINDOWS(NUM_WINDOWS)
) u_awt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .status_o          (status_o),
  .hit_window_o      (hit_window_o),
  .translated_addr_o (translated_addr_o)
);
